>>> sv/assert_macros.svh
// Assertion macros used by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> sv/ptt_pkg.sv
// Package with codes and constants of the periodic timer table.
package ptt_pkg;
    localparam int TIMER_SLOTS_DEF = 32;
    localparam logic [15:0] MIN_CHECK_RST = 16'd100;
    localparam logic [15:0] GRACE_RST = 16'd1000;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0, ACT_REMOVE = 2'd1, ACT_CHECK = 2'd2, ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_ADDED = 3'd0, ST_UPDATED = 3'd1, ST_FULL = 3'd2, ST_REMOVED = 3'd3,
        ST_NOT_FOUND = 3'd4, ST_SKIPPED = 3'd5, ST_DONE = 3'd6, ST_RSVD = 3'd7
    } t_status;

    localparam logic CFG_MIN_CHECK = 1'b0;
    localparam logic CFG_GRACE = 1'b1;
endpackage

>>> sv/periodic_timer_table.sv
// Top level of the periodic timer table: command decode, slot scan and result output.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | tdata: action,client_key,event_id,
//            |           |                        |        period_ms,user_tag,now_ms
//  m_axis    | out       | tvalid/tready, tlast   | tdata: status,fired,fired_client,
//            |           |                        |        fired_event,fired_tag,fire_count
//  cfg       | in        | i_cfg_valid/o_cfg_ready| index (1 bit), data (16 bit)
//
// Clear and a skipped check set their result on accept, with no scan. Add and remove scan
// the slot memory one entry per cycle. An accepted check marks due slots in one scan, then
// runs one scan per fire to pick the smallest key, and a last scan that finds no due slot.
// The slot memory has one read and one write port and a registered read. Reset clears the
// valid bits at once.
// A stalled output holds the result word; the next result step waits until it is taken.
`include "assert_macros.svh"
module periodic_timer_table #(
    parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0], client_key[17:2], event_id[49:18], period_ms[81:50],
    // user_tag[113:82], now_ms[161:114], zero fill [167:162]
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], fired[3], fired_client[19:4], fired_event[51:20],
    // fired_tag[83:52], fire_count[89:84], zero fill [95:90]
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int CW = IW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,   // find key / free slot, or mark due slots on check
        S_WRITE = 7'b0000100,   // write back add / remove
        S_PICK  = 7'b0001000,   // find smallest due key
        S_FIRE  = 7'b0010000,   // read picked slot for its result
        S_OUT   = 7'b0100000,   // never entered; returns to idle
        S_SUM   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [15:0] client;
        logic [31:0] event_id;
        logic [31:0] period;
        logic [31:0] tag;
        logic [47:0] start;
    } t_slot;

    t_slot r_mem [TIMER_SLOTS];
    t_slot r_rd;
    logic  [TIMER_SLOTS-1:0] r_valid, n_valid, r_due, n_due;

    t_state r_state, n_state;
    logic [1:0]  r_act, n_act;
    logic [15:0] r_client, n_client;
    logic [31:0] r_event, n_event, r_period, n_period, r_tag, n_tag;
    logic [47:0] r_now, n_now, r_last_chk, n_last_chk;
    logic [15:0] r_min_chk, r_grace;
    logic [CW-1:0] r_idx, n_idx;        // address issued last cycle
    logic [IW-1:0] r_hit, n_hit, r_free, n_free, r_best, n_best;
    logic          r_hit_ok, n_hit_ok, r_free_ok, n_free_ok, r_best_ok, n_best_ok;
    logic [47:0]   r_best_key, n_best_key;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_ovalid, n_ovalid, r_olast, n_olast;
    logic [89:0]   r_odata, n_odata;

    logic          mem_we;
    logic [IW-1:0] mem_wa, rd_addr;
    t_slot         mem_wd;
    logic [IW-1:0] cur;
    logic [47:0]   cur_key;
    logic signed [49:0] late, dchk;
    logic          out_free;

    assign cur = r_idx[IW-1:0];
    assign cur_key = {r_rd.client, ~r_rd.event_id[31], r_rd.event_id[30:0]};
    assign late = $signed({2'b0, r_now}) - $signed({2'b0, r_rd.start})
                - $signed({18'b0, r_rd.period});
    assign dchk = $signed({2'b0, s_axis_tdata[161:114]}) - $signed({2'b0, r_last_chk});
    assign out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast = r_olast;
    assign m_axis_tdata = {6'b0, r_odata};

    // slot memory, one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state; n_act = r_act; n_client = r_client; n_event = r_event;
        n_period = r_period; n_tag = r_tag; n_now = r_now; n_last_chk = r_last_chk;
        n_valid = r_valid; n_due = r_due; n_idx = r_idx;
        n_hit = r_hit; n_hit_ok = r_hit_ok; n_free = r_free; n_free_ok = r_free_ok;
        n_best = r_best; n_best_ok = r_best_ok; n_best_key = r_best_key; n_cnt = r_cnt;
        n_ovalid = r_ovalid && !m_axis_tready; n_olast = r_olast; n_odata = r_odata;
        mem_we = 1'b0; mem_wa = cur; mem_wd = r_rd; rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_act = s_axis_tdata[1:0];
                    n_client = s_axis_tdata[17:2];
                    n_event = s_axis_tdata[49:18];
                    n_period = s_axis_tdata[81:50];
                    n_tag = s_axis_tdata[113:82];
                    n_now = s_axis_tdata[161:114];
                    n_hit_ok = 1'b0; n_free_ok = 1'b0; n_cnt = '0; n_due = '0;
                    n_idx = '0; rd_addr = '0;
                    case (ptt_pkg::t_action'(s_axis_tdata[1:0]))
                        ptt_pkg::ACT_CLEAR: begin
                            n_valid = '0;
                            n_ovalid = 1'b1; n_olast = 1'b1;
                            n_odata = {87'b0, ptt_pkg::ST_REMOVED};
                        end
                        ptt_pkg::ACT_CHECK: begin
                            if (dchk < $signed({34'b0, r_min_chk})) begin
                                n_ovalid = 1'b1; n_olast = 1'b1;
                                n_odata = {87'b0, ptt_pkg::ST_SKIPPED};
                            end else begin
                                n_last_chk = s_axis_tdata[161:114];
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                // r_rd holds slot r_idx; issue the next read
                if (ptt_pkg::t_action'(r_act) == ptt_pkg::ACT_CHECK) begin
                    if (r_valid[cur] && late >= $signed({34'b0, r_grace})) begin
                        n_due[cur] = 1'b1;
                        mem_we = 1'b1;
                        mem_wd.start = r_now;
                    end
                end else begin
                    if (r_valid[cur] && r_rd.client == r_client && r_rd.event_id == r_event
                        && !r_hit_ok) begin
                        n_hit = cur; n_hit_ok = 1'b1;
                    end
                    if (!r_valid[cur] && !r_free_ok) begin
                        n_free = cur; n_free_ok = 1'b1;
                    end
                end
                if (r_idx == CW'(TIMER_SLOTS - 1)) begin
                    n_state = (ptt_pkg::t_action'(r_act) == ptt_pkg::ACT_CHECK) ? S_PICK
                                                                                : S_WRITE;
                    n_idx = '0; n_best_ok = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
                rd_addr = n_idx[IW-1:0];
            end
            S_WRITE: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_olast = 1'b1; n_odata = '0;
                    n_state = S_IDLE;
                    if (ptt_pkg::t_action'(r_act) == ptt_pkg::ACT_REMOVE) begin
                        if (r_hit_ok) begin
                            n_valid[r_hit] = 1'b0;
                            n_odata[2:0] = ptt_pkg::ST_REMOVED;
                        end else begin
                            n_odata[2:0] = ptt_pkg::ST_NOT_FOUND;
                        end
                    end else if (r_hit_ok || r_free_ok) begin
                        mem_we = 1'b1;
                        mem_wa = r_hit_ok ? r_hit : r_free;
                        mem_wd = '{client: r_client, event_id: r_event, period: r_period,
                                   tag: r_tag, start: r_now};
                        n_valid[mem_wa] = 1'b1;
                        n_odata[2:0] = r_hit_ok ? ptt_pkg::ST_UPDATED : ptt_pkg::ST_ADDED;
                    end else begin
                        n_odata[2:0] = ptt_pkg::ST_FULL;
                    end
                end
            end
            S_PICK: begin
                if (r_due[cur] && (!r_best_ok || cur_key < r_best_key)) begin
                    n_best = cur; n_best_ok = 1'b1; n_best_key = cur_key;
                end
                if (r_idx == CW'(TIMER_SLOTS - 1)) begin
                    n_idx = '0;
                    n_state = (n_best_ok) ? S_FIRE : S_SUM;
                    rd_addr = n_best;
                end else begin
                    n_idx = r_idx + 1'b1;
                    rd_addr = n_idx[IW-1:0];
                end
            end
            S_FIRE: begin
                rd_addr = r_best;
                if (out_free) begin
                    n_ovalid = 1'b1; n_olast = 1'b0;
                    n_odata = {6'b0, r_rd.tag, r_rd.event_id, r_rd.client, 1'b1,
                               ptt_pkg::ST_DONE};
                    n_due[r_best] = 1'b0;
                    if (r_cnt != 6'h3F) n_cnt = r_cnt + 1'b1;
                    n_best_ok = 1'b0; n_idx = '0; rd_addr = '0;
                    n_state = S_PICK;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_olast = 1'b1;
                    n_odata = {r_cnt, 81'b0, ptt_pkg::ST_DONE};
                    n_state = S_IDLE;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_due <= '0; r_ovalid <= 1'b0;
            r_last_chk <= '0; r_min_chk <= ptt_pkg::MIN_CHECK_RST;
            r_grace <= ptt_pkg::GRACE_RST; r_idx <= '0;
            r_hit_ok <= 1'b0; r_free_ok <= 1'b0; r_best_ok <= 1'b0;
            r_cnt <= '0; r_olast <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_due <= n_due;
            r_ovalid <= n_ovalid; r_last_chk <= n_last_chk; r_idx <= n_idx;
            r_hit_ok <= n_hit_ok; r_free_ok <= n_free_ok;
            r_best_ok <= n_best_ok; r_cnt <= n_cnt; r_olast <= n_olast;
            if (i_cfg_valid) begin
                if (i_cfg_index == ptt_pkg::CFG_MIN_CHECK) r_min_chk <= i_cfg_data;
                else r_grace <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_client <= n_client; r_event <= n_event; r_period <= n_period;
        r_tag <= n_tag; r_now <= n_now; r_hit <= n_hit; r_free <= n_free;
        r_best <= n_best; r_best_key <= n_best_key; r_odata <= n_odata;
    end

    `ASSERT_IMPLY(a_idle_no_due, i_clk, i_rst_n, r_state == S_IDLE, r_due == '0)
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_ovalid && !m_axis_tready, r_ovalid)
    `ASSERT_IMPLY(a_fire_due, i_clk, i_rst_n, r_state == S_FIRE, r_due[r_best])
    `ASSERT_IMPLY(a_state_hot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule
